### design/mmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared types and constants of the multichannel running median filter.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam int CHANNELS = 4;
  localparam int WINDOW   = 5;
  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 3;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [WINDOW-1:0] row_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    sample_t           sample;
  } in_t;

  typedef struct packed {
    sample_t median;
    logic    cleared;
  } out_t;

endpackage

### design/multichannel_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_median_filter
// Running median over the last five samples of each of four channels.
// ----------------------------------------------------------------------------
// A request names a channel and brings one signed 24-bit sample; every request
// gives exactly one result, in order. The filter takes one request per clock
// while the output is not stalled. The window stage updates the channel's
// window and captures a copy of it; the output register then takes the copy
// as ranked by parallel comparators. While a channel's window is filling the
// result is the upper median of the samples held so far. A channel number
// above the last channel empties every window and returns -1 with the cleared
// flag set. A stalled output register holds its result while one more request
// is still taken into the window stage.
module multichannel_median_filter
  import mmf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  // window state
  row_t             win_q [CHANNELS];
  logic [CNT_W-1:0] fill_q [CHANNELS];

  // window stage
  logic             s1_valid_q;
  row_t             s1_row_q;
  logic [CNT_W-1:0] s1_cnt_q;
  logic             s1_clr_q;

  // result register
  logic out_valid_q;
  out_t out_q;

  logic              in_acc, s1_adv, out_free;
  logic [CH_IDX_W-1:0] ch_idx;
  logic              in_range;
  logic [CNT_W-1:0]  cur_cnt, new_cnt;
  row_t              new_row;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  assign ch_idx   = CH_IDX_W'(in_i.channel);
  assign in_range = 32'(in_i.channel) < CHANNELS;
  assign cur_cnt  = fill_q[ch_idx];

  // insert while filling, shift out the oldest once full
  always_comb begin
    new_row = win_q[ch_idx];
    new_cnt = cur_cnt;
    if (cur_cnt < CNT_W'(WINDOW)) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (CNT_W'(k) == cur_cnt) new_row[k] = in_i.sample;
      end
      new_cnt = cur_cnt + CNT_W'(1);
    end else begin
      for (int k = 0; k < WINDOW - 1; k++) new_row[k] = win_q[ch_idx][k+1];
      new_row[WINDOW-1] = in_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) fill_q[c] <= '0;
    end else if (in_acc) begin
      if (in_range) begin
        fill_q[ch_idx] <= new_cnt;
      end else begin
        for (int c = 0; c < CHANNELS; c++) fill_q[c] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      win_q[ch_idx] <= new_row;
    end
    if (in_acc) begin
      s1_row_q <= new_row;
      s1_cnt_q <= new_cnt;
      s1_clr_q <= !in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // stable rank of each held sample, then pick the one at count/2
  logic [CNT_W-1:0] rank [WINDOW];
  sample_t          pick;

  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i && CNT_W'(j) < s1_cnt_q) begin
          if (s1_row_q[j] < s1_row_q[i] ||
              (j < i && s1_row_q[j] == s1_row_q[i])) begin
            rank[i] = rank[i] + CNT_W'(1);
          end
        end
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      if (CNT_W'(i) < s1_cnt_q && rank[i] == (s1_cnt_q >> 1)) begin
        pick = pick | s1_row_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.median  <= s1_clr_q ? '1 : pick;
      out_q.cleared <= s1_clr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### design/mmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mmf_checker
  import mmf_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  // a cleared result always carries all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.cleared) |-> (out_o.median == '1))
    else $error("cleared result without all-ones median");

  // requests are only held off behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("request stalled with output free");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result dropped or changed");

  // a request taken while no result is shown is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> ##1 out_valid_o)
    else $error("result missing after request");

endmodule

bind multichannel_median_filter mmf_checker u_mmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

### tb/sv/tb_multichannel_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_median_filter
// Self-checking bench for the four-channel running median filter. Requests
// come from a queue through a clocked driver with random gaps. A clocked
// monitor with random back-pressure checks every result in order against
// medians worked out from a shadow copy of each channel's window.
// ----------------------------------------------------------------------------
module tb_multichannel_median_filter;
  import mmf_pkg::*;

  localparam int      IDLE_LIMIT = 1000;
  localparam int      LONG_HOLD  = 120;
  localparam int      CHUNK      = 150;
  localparam int      CHUNKS     = 13;
  localparam int      MAX_PRINTS = 100;
  localparam sample_t S_MAX      = 24'sh7FFFFF;
  localparam sample_t S_MIN      = 24'sh800000;

  typedef enum int {PACE_FULL, PACE_SPARSE, PACE_BURSTY} pace_e;

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req_data  = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_t res_data;

  // shadow windows, oldest sample first
  sample_t chan_history [CHANNELS][WINDOW];
  int      chan_depth   [CHANNELS];

  in_t   pending_requests [$];
  out_t  median_queue     [$];
  pace_e send_pace = PACE_FULL;
  pace_e recv_pace = PACE_FULL;
  int    requests_queued = 0;
  int    requests_taken  = 0;
  int    send_wait, send_wait_now;
  int    recv_wait, recv_wait_now;
  int    hold_requests = 0;
  int    holds_done, hold_left;
  int    idle_cycles = 0;
  int    error_count = 0;

  multichannel_median_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_i       (req_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_o      (res_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int draw_gap(pace_e pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_SPARSE: return $urandom_range(0, 19);
      default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  // updates the shadow window and returns the median the filter should give
  function automatic out_t filter_request(in_t req);
    out_t    res;
    sample_t sorted_vals [WINDOW];
    sample_t key;
    int      ch, n, j;
    res.cleared = 1'b0;
    if (req.channel >= CHANNELS) begin
      for (int c = 0; c < CHANNELS; c++) chan_depth[c] = 0;
      res.median  = '1;
      res.cleared = 1'b1;
      return res;
    end
    ch = req.channel;
    if (chan_depth[ch] < WINDOW) begin
      chan_history[ch][chan_depth[ch]] = req.sample;
      chan_depth[ch]++;
    end else begin
      for (int i = 0; i < WINDOW - 1; i++) chan_history[ch][i] = chan_history[ch][i+1];
      chan_history[ch][WINDOW-1] = req.sample;
    end
    n = chan_depth[ch];
    // insertion sort of the occupied slots
    for (int i = 0; i < n; i++) begin
      key = chan_history[ch][i];
      j = i;
      while (j > 0 && sorted_vals[j-1] > key) begin
        sorted_vals[j] = sorted_vals[j-1];
        j--;
      end
      sorted_vals[j] = key;
    end
    res.median = sorted_vals[n/2];
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    if (error_count < MAX_PRINTS)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic queue_request(logic [CHAN_W-1:0] ch, sample_t s);
    in_t req;
    req.channel = ch;
    req.sample  = s;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_data  <= '0;
      send_wait <= 0;
    end else begin
      if (req_valid && req_ready) begin
        median_queue.push_back(filter_request(req_data));
        requests_taken <= requests_taken + 1;
      end
      if (!req_valid || req_ready) begin
        send_wait_now = req_valid ? draw_gap(send_pace) : send_wait;
        if (send_wait_now > 0) begin
          req_valid <= 1'b0;
          send_wait <= send_wait_now - 1;
        end else if (pending_requests.size() != 0) begin
          req_data  <= pending_requests.pop_front();
          req_valid <= 1'b1;
          send_wait <= 0;
        end else begin
          req_valid <= 1'b0;
          send_wait <= 0;
        end
      end
    end
  end

  // monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      recv_wait  <= 0;
      hold_left  <= 0;
      holds_done <= 0;
    end else begin
      recv_wait_now = recv_wait;
      if (res_valid && res_ready) begin
        if (median_queue.size() == 0) begin
          report("unexpected result, median", res_data.median, 0);
        end else begin
          if (res_data.median !== median_queue[0].median)
            report("median", res_data.median, median_queue[0].median);
          if (res_data.cleared !== median_queue[0].cleared)
            report("cleared", res_data.cleared, median_queue[0].cleared);
          void'(median_queue.pop_front());
        end
        recv_wait_now = draw_gap(recv_pace);
      end
      if (holds_done != hold_requests) begin
        // long stall so the filter fills and pushes back on requests
        holds_done <= holds_done + 1;
        hold_left  <= LONG_HOLD;
        res_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if (recv_wait_now != 0) begin
        recv_wait_now = recv_wait_now - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
      recv_wait <= recv_wait_now;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (res_valid && res_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [CHAN_W-1:0] ch;
    sample_t           s;
    for (int c = 0; c < CHANNELS; c++) chan_depth[c] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // window filling, extremes, zero and all-ones data, then a shift
    queue_request(3'd0, 24'sd0);
    queue_request(3'd0, S_MAX);
    queue_request(3'd0, S_MIN);
    queue_request(3'd0, -24'sd1);
    queue_request(3'd0, 24'sd0);
    queue_request(3'd0, 24'sd5);
    // equal samples
    queue_request(3'd1, S_MIN);
    queue_request(3'd1, S_MIN);
    queue_request(3'd1, S_MIN);
    queue_request(3'd2, 24'sh555555);
    queue_request(3'd3, 24'sh2AAAAA);
    queue_request(3'd3, 24'shAAAAAA);
    // clears from every out-of-range channel, windows refill afterwards
    queue_request(3'd4, 24'sd0);
    queue_request(3'd0, 24'sd123);
    queue_request(3'd5, S_MIN);
    queue_request(3'd1, S_MAX);
    queue_request(3'd6, 24'sh555555);
    queue_request(3'd7, S_MAX);
    queue_request(3'd0, -24'sd7);
    queue_request(3'd0, 24'sd9);
    queue_request(3'd3, 24'sd0);
    wait (requests_taken == requests_queued);

    for (int k = 0; k < CHUNKS; k++) begin
      @(negedge clk_i);
      send_pace = pace_e'($urandom_range(0, 2));
      recv_pace = pace_e'($urandom_range(0, 2));
      if (k == 0) begin
        send_pace = PACE_FULL;
        recv_pace = PACE_FULL;
      end
      if (k == 1) begin
        send_pace = PACE_FULL;
        hold_requests++;
      end
      for (int i = 0; i < CHUNK; i++) begin
        // rare clears so most windows get full and start shifting
        ch = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(4, 7))
                                          : 3'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: s = sample_t'($urandom);
          5, 6, 7:       s = sample_t'($urandom_range(0, 6)) - 24'sd3;
          8:             s = $urandom_range(0, 1) ? S_MAX : S_MIN;
          default:       s = sample_t'($urandom_range(0, 1)) - 24'sd1;
        endcase
        queue_request(ch, s);
      end
      wait (requests_taken == requests_queued);
    end

    wait (median_queue.size() == 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
